// ===== sv/obc_pkg.sv =====
// obc_pkg: shared constants, types, the octant side table and its inverse for the octree box octant classifier
// no dependencies
package obc_pkg;

    localparam int COORD_BITS = 32;
    localparam int NUM_AXES = 3;
    localparam int NUM_OCTANTS = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);

    // register indexes of the configuration port
    localparam logic [2:0] REG_NODE_LOW_X  = 3'd0;
    localparam logic [2:0] REG_NODE_LOW_Y  = 3'd1;
    localparam logic [2:0] REG_NODE_LOW_Z  = 3'd2;
    localparam logic [2:0] REG_NODE_HIGH_X = 3'd3;
    localparam logic [2:0] REG_NODE_HIGH_Y = 3'd4;
    localparam logic [2:0] REG_NODE_HIGH_Z = 3'd5;

    // home octant code when no single octant holds the box
    localparam logic [3:0] HOME_NONE = 4'd8;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [NUM_AXES-1:0][COORD_BITS-1:0] vec3_t;

    // per octant: bit 0 x on + side, bit 1 y on + side, bit 2 z on + side
    localparam logic [NUM_OCTANTS-1:0][2:0] OCT_SIDES = {
        3'd1, 3'd0, 3'd2, 3'd3, 3'd5, 3'd4, 3'd6, 3'd7
    };

    // classified query handed from front to back
    typedef struct packed {
        logic       in_node;
        logic [3:0] home;
        logic       fits;
        logic [7:0] mask;
        vec3_t      qlo;
        vec3_t      qhi;
        vec3_t      ctr;
    } obc_entry_t;

    // side code to octant number (inverse of OCT_SIDES)
    function automatic logic [2:0] side_to_octant(input logic [2:0] side);
        logic [2:0] oct;
        oct = 3'd0;
        for (int k = 0; k < NUM_OCTANTS; k++) begin
            if (OCT_SIDES[k] == side) begin
                oct = 3'(k);
            end
        end
        return oct;
    endfunction

endpackage

// ===== sv/obc_front.sv =====
// obc_front: accepts query boxes, forms the node centre and classifies each query
// depends on obc_pkg
module obc_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  obc_pkg::vec3_t      s_qlo,
    input  obc_pkg::vec3_t      s_qhi,
    input  obc_pkg::vec3_t      node_lo,
    input  obc_pkg::vec3_t      node_hi,
    output logic                q_push,
    input  logic                q_full,
    output obc_pkg::obc_entry_t q_entry
);

    logic           a_valid_reg;
    obc_pkg::vec3_t a_qlo_reg;
    obc_pkg::vec3_t a_qhi_reg;
    obc_pkg::vec3_t a_ctr_reg;
    obc_pkg::vec3_t ctr_next;

    logic [2:0] ge_lo;
    logic [2:0] ge_hi;
    logic       in_node;
    logic [3:0] home;
    logic [7:0] mask;
    logic [2:0] side;
    logic       ok;

    assign s_ready = !a_valid_reg || !q_full;
    assign q_push  = a_valid_reg && !q_full;

    // floor((lo + hi) / 2) with one extra bit so the sum never overflows
    always_comb begin
        logic [obc_pkg::COORD_BITS:0] sum;
        for (int a = 0; a < obc_pkg::NUM_AXES; a++) begin
            sum = {node_lo[a][obc_pkg::COORD_BITS-1], node_lo[a]}
                + {node_hi[a][obc_pkg::COORD_BITS-1], node_hi[a]};
            ctr_next[a] = sum[obc_pkg::COORD_BITS:1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            a_valid_reg <= 1'b1;
        end else if (q_push) begin
            a_valid_reg <= 1'b0;
        end
        if (s_valid && s_ready) begin
            a_qlo_reg <= s_qlo;
            a_qhi_reg <= s_qhi;
            a_ctr_reg <= ctr_next;
        end
    end

    always_comb begin
        in_node = 1'b1;
        for (int a = 0; a < obc_pkg::NUM_AXES; a++) begin
            ge_lo[a] = $signed(a_qlo_reg[a]) >= $signed(a_ctr_reg[a]);
            ge_hi[a] = $signed(a_qhi_reg[a]) >= $signed(a_ctr_reg[a]);
            if ($signed(a_qlo_reg[a]) < $signed(node_lo[a])
                || $signed(a_qhi_reg[a]) > $signed(node_hi[a])) begin
                in_node = 1'b0;
            end
        end

        // first octant that wholly holds the box
        home = obc_pkg::HOME_NONE;
        for (int k = obc_pkg::NUM_OCTANTS - 1; k >= 0; k--) begin
            ok = 1'b1;
            for (int a = 0; a < obc_pkg::NUM_AXES; a++) begin
                if (obc_pkg::OCT_SIDES[k][a]) begin
                    ok = ok && ge_lo[a];
                end else begin
                    ok = ok && !ge_hi[a];
                end
            end
            if (ok) begin
                home = 4'(k);
            end
        end

        // octants of the eight corners
        mask = '0;
        for (int k = 0; k < obc_pkg::NUM_OCTANTS; k++) begin
            for (int a = 0; a < obc_pkg::NUM_AXES; a++) begin
                side[a] = k[a] ? ge_hi[a] : ge_lo[a];
            end
            mask[obc_pkg::side_to_octant(side)] = 1'b1;
        end
    end

    always_comb begin
        q_entry.in_node = in_node;
        q_entry.home    = home;
        q_entry.fits    = in_node && (home != obc_pkg::HOME_NONE);
        q_entry.mask    = mask;
        q_entry.qlo     = a_qlo_reg;
        q_entry.qhi     = a_qhi_reg;
        q_entry.ctr     = a_ctr_reg;
    end

endmodule

// ===== sv/obc_queue.sv =====
// obc_queue: short queue of classified queries between front and back
// depends on obc_pkg
module obc_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  obc_pkg::obc_entry_t push_entry,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output obc_pkg::obc_entry_t head
);

    obc_pkg::obc_entry_t slot_reg [obc_pkg::QUEUE_DEPTH];

    logic [obc_pkg::QPTR_BITS-1:0] wr_ptr_reg;
    logic [obc_pkg::QPTR_BITS-1:0] rd_ptr_reg;
    logic [obc_pkg::QPTR_BITS:0]   count_reg;

    assign full  = count_reg == (obc_pkg::QPTR_BITS+1)'(obc_pkg::QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("queue overrun");

    a_no_pop_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        empty |-> !pop)
        else $error("queue underrun");

    a_count_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count lost a push");

endmodule

// ===== sv/obc_back.sv =====
// obc_back: walks the touched octants of each query and emits clipped child boxes
// depends on obc_pkg
module obc_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_empty,
    input  obc_pkg::obc_entry_t q_head,
    output logic                q_pop,
    input  obc_pkg::vec3_t      node_lo,
    input  obc_pkg::vec3_t      node_hi,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_inside,
    output logic [3:0]          m_home,
    output logic                m_fits,
    output logic [7:0]          m_mask,
    output logic [2:0]          m_octant,
    output obc_pkg::vec3_t      m_clo,
    output obc_pkg::vec3_t      m_chi,
    output logic                m_final
);

    logic                cur_valid_reg;
    logic [7:0]          cur_rem_reg;
    obc_pkg::obc_entry_t cur_reg;

    logic                m_valid_reg;
    logic                m_inside_reg;
    logic [3:0]          m_home_reg;
    logic                m_fits_reg;
    logic [7:0]          m_mask_reg;
    logic [2:0]          m_octant_reg;
    obc_pkg::vec3_t      m_clo_reg;
    obc_pkg::vec3_t      m_chi_reg;
    logic                m_final_reg;

    logic           emit;
    logic           last;
    logic [2:0]     oct;
    logic [7:0]     rem_next;
    obc_pkg::vec3_t clo_next;
    obc_pkg::vec3_t chi_next;

    assign emit  = cur_valid_reg && (!m_valid_reg || m_ready);
    assign last  = rem_next == '0;
    assign q_pop = !q_empty && (!cur_valid_reg || (emit && last));

    always_comb begin
        logic [obc_pkg::COORD_BITS-1:0] child_lo;
        logic [obc_pkg::COORD_BITS-1:0] child_hi;
        // lowest touched octant still to go
        oct = 3'd0;
        for (int k = obc_pkg::NUM_OCTANTS - 1; k >= 0; k--) begin
            if (cur_rem_reg[k]) begin
                oct = 3'(k);
            end
        end
        rem_next      = cur_rem_reg;
        rem_next[oct] = 1'b0;
        for (int a = 0; a < obc_pkg::NUM_AXES; a++) begin
            if (obc_pkg::OCT_SIDES[oct][a]) begin
                child_lo = cur_reg.ctr[a];
                child_hi = node_hi[a];
            end else begin
                child_lo = node_lo[a];
                child_hi = cur_reg.ctr[a];
            end
            clo_next[a] = ($signed(cur_reg.qlo[a]) > $signed(child_lo))
                        ? cur_reg.qlo[a] : child_lo;
            chi_next[a] = ($signed(cur_reg.qhi[a]) < $signed(child_hi))
                        ? cur_reg.qhi[a] : child_hi;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (q_pop) begin
                cur_valid_reg <= 1'b1;
            end else if (emit && last) begin
                cur_valid_reg <= 1'b0;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (q_pop) begin
            cur_reg     <= q_head;
            cur_rem_reg <= q_head.mask;
        end else if (emit) begin
            cur_rem_reg <= rem_next;
        end
        if (emit) begin
            m_inside_reg <= cur_reg.in_node;
            m_home_reg   <= cur_reg.home;
            m_fits_reg   <= cur_reg.fits;
            m_mask_reg   <= cur_reg.mask;
            m_octant_reg <= oct;
            m_clo_reg    <= clo_next;
            m_chi_reg    <= chi_next;
            m_final_reg  <= last;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_inside = m_inside_reg;
    assign m_home   = m_home_reg;
    assign m_fits   = m_fits_reg;
    assign m_mask   = m_mask_reg;
    assign m_octant = m_octant_reg;
    assign m_clo    = m_clo_reg;
    assign m_chi    = m_chi_reg;
    assign m_final  = m_final_reg;

    a_rem_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_valid_reg |-> (cur_rem_reg != '0))
        else $error("active query with no octants left");

    a_emit_in_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> cur_reg.mask[oct])
        else $error("emitted octant not touched");

    a_rem_subset: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_valid_reg |-> ((cur_rem_reg & ~cur_reg.mask) == '0))
        else $error("remaining octants outside touched mask");

endmodule

// ===== sv/octree_box_octant_classifier.sv =====
// octree_box_octant_classifier: top level, configuration registers, front, queue and back
// depends on obc_pkg, obc_front, obc_queue, obc_back
//
// Each query box gets one result per octant of the node that one of its eight corners falls
// in, from one to eight results in ascending octant order, the last marked by final_result.
// The back end emits one clipped result per touched octant (1 to 8), one per cycle unless
// m_ready stalls it; the front end takes a new query every cycle while the four-entry queue
// between them has room, so a burst of queries is absorbed while results drain. A query
// passes the front register, a queue slot and the back current register to its first result.
// The user must write the node box registers through cfg_wr_* only while no query is in
// flight; the block itself does not enforce it. Indexes 6 and 7 are ignored. Coordinates are
// signed two's complement, Q16.16 at the default width; centre floor((low + high) / 2), no overflow.
module octree_box_octant_classifier (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // configuration write port
    input  logic                                   cfg_wr_en,
    input  logic [2:0]                             cfg_wr_index,
    input  logic [obc_pkg::COORD_BITS-1:0]         cfg_wr_data,
    // query input channel
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [obc_pkg::COORD_BITS-1:0]  s_query_low_x,
    input  logic signed [obc_pkg::COORD_BITS-1:0]  s_query_low_y,
    input  logic signed [obc_pkg::COORD_BITS-1:0]  s_query_low_z,
    input  logic signed [obc_pkg::COORD_BITS-1:0]  s_query_high_x,
    input  logic signed [obc_pkg::COORD_BITS-1:0]  s_query_high_y,
    input  logic signed [obc_pkg::COORD_BITS-1:0]  s_query_high_z,
    // result channel
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic                                   m_inside_node,
    output logic [3:0]                             m_home_octant,
    output logic                                   m_fits_child,
    output logic [7:0]                             m_touched_mask,
    output logic [2:0]                             m_clip_octant,
    output logic signed [obc_pkg::COORD_BITS-1:0]  m_clip_low_x,
    output logic signed [obc_pkg::COORD_BITS-1:0]  m_clip_low_y,
    output logic signed [obc_pkg::COORD_BITS-1:0]  m_clip_low_z,
    output logic signed [obc_pkg::COORD_BITS-1:0]  m_clip_high_x,
    output logic signed [obc_pkg::COORD_BITS-1:0]  m_clip_high_y,
    output logic signed [obc_pkg::COORD_BITS-1:0]  m_clip_high_z,
    output logic                                   m_final_result
);

    // node box corners, one register per axis
    obc_pkg::vec3_t node_lo_reg;
    obc_pkg::vec3_t node_hi_reg;

    obc_pkg::vec3_t      s_qlo;
    obc_pkg::vec3_t      s_qhi;
    obc_pkg::vec3_t      m_clo;
    obc_pkg::vec3_t      m_chi;

    // front to queue
    logic                q_push;
    logic                q_full;
    obc_pkg::obc_entry_t q_entry;

    // queue to back
    logic                q_pop;
    logic                q_empty;
    obc_pkg::obc_entry_t q_head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_lo_reg <= '0;
            node_hi_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                obc_pkg::REG_NODE_LOW_X:  node_lo_reg[0] <= cfg_wr_data;
                obc_pkg::REG_NODE_LOW_Y:  node_lo_reg[1] <= cfg_wr_data;
                obc_pkg::REG_NODE_LOW_Z:  node_lo_reg[2] <= cfg_wr_data;
                obc_pkg::REG_NODE_HIGH_X: node_hi_reg[0] <= cfg_wr_data;
                obc_pkg::REG_NODE_HIGH_Y: node_hi_reg[1] <= cfg_wr_data;
                obc_pkg::REG_NODE_HIGH_Z: node_hi_reg[2] <= cfg_wr_data;
                default: begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    // axis order x, y, z
    assign s_qlo = {s_query_low_z, s_query_low_y, s_query_low_x};
    assign s_qhi = {s_query_high_z, s_query_high_y, s_query_high_x};

    // centre and classification
    obc_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_qlo   (s_qlo),
        .s_qhi   (s_qhi),
        .node_lo (node_lo_reg),
        .node_hi (node_hi_reg),
        .q_push  (q_push),
        .q_full  (q_full),
        .q_entry (q_entry)
    );

    // decouples classification from the per-octant walk
    obc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .empty      (q_empty),
        .head       (q_head)
    );

    // one clipped child box per cycle into the output register, unless m_ready stalls it
    obc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .node_lo  (node_lo_reg),
        .node_hi  (node_hi_reg),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_inside (m_inside_node),
        .m_home   (m_home_octant),
        .m_fits   (m_fits_child),
        .m_mask   (m_touched_mask),
        .m_octant (m_clip_octant),
        .m_clo    (m_clo),
        .m_chi    (m_chi),
        .m_final  (m_final_result)
    );

    assign m_clip_low_x  = m_clo[0];
    assign m_clip_low_y  = m_clo[1];
    assign m_clip_low_z  = m_clo[2];
    assign m_clip_high_x = m_chi[0];
    assign m_clip_high_y = m_chi[1];
    assign m_clip_high_z = m_chi[2];

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking bench for octree_box_octant_classifier, directed then random query boxes
// depends on obc_pkg and the classifier rtl; predicts every clipped result and checks them in order

module tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS = 40;
    localparam int BUSY_PCT = 22;
    localparam int Q_ONE = 65536;

    localparam obc_pkg::coord_t COORD_MIN = {1'b1, {(obc_pkg::COORD_BITS-1){1'b0}}};
    localparam obc_pkg::coord_t COORD_MAX = ~COORD_MIN;
    localparam longint COORD_TOP = (longint'(1) <<< (obc_pkg::COORD_BITS-1)) - 1;

    // register indexes past the node box, writes there must be dropped
    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;

    // per octant: bit 0 x on + side, bit 1 y on + side, bit 2 z on + side
    localparam logic [7:0][2:0] SIDES_OF_OCTANT = {
        3'd1, 3'd0, 3'd2, 3'd3, 3'd5, 3'd4, 3'd6, 3'd7
    };
    // side code to octant number
    localparam logic [7:0][2:0] OCTANT_OF_SIDE = {
        3'd0, 3'd1, 3'd3, 3'd2, 3'd4, 3'd5, 3'd7, 3'd6
    };

    typedef enum int {NODE_WIDE, NODE_SMALL, NODE_MIXED} node_style_t;

    // one clipped result as the block should emit it
    typedef struct packed {
        logic           in_node;
        logic [3:0]     home;
        logic           fits;
        logic [7:0]     mask;
        logic [2:0]     octant;
        obc_pkg::vec3_t lo;
        obc_pkg::vec3_t hi;
        logic           last;
    } clip_t;

    logic            aclk = 1'b0;
    logic            aresetn = 1'b0;
    logic            cfg_wr_en = 1'b0;
    logic [2:0]      cfg_wr_index = '0;
    obc_pkg::coord_t cfg_wr_data = '0;

    logic            s_valid = 1'b0;
    logic            s_ready;
    obc_pkg::coord_t s_query_low_x = '0;
    obc_pkg::coord_t s_query_low_y = '0;
    obc_pkg::coord_t s_query_low_z = '0;
    obc_pkg::coord_t s_query_high_x = '0;
    obc_pkg::coord_t s_query_high_y = '0;
    obc_pkg::coord_t s_query_high_z = '0;

    logic            m_valid;
    logic            m_ready = 1'b1;
    logic            m_inside_node;
    logic [3:0]      m_home_octant;
    logic            m_fits_child;
    logic [7:0]      m_touched_mask;
    logic [2:0]      m_clip_octant;
    obc_pkg::coord_t m_clip_low_x;
    obc_pkg::coord_t m_clip_low_y;
    obc_pkg::coord_t m_clip_low_z;
    obc_pkg::coord_t m_clip_high_x;
    obc_pkg::coord_t m_clip_high_y;
    obc_pkg::coord_t m_clip_high_z;
    logic            m_final_result;

    // local copy of the node box registers, reset value zero
    obc_pkg::vec3_t node_lo = '0;
    obc_pkg::vec3_t node_hi = '0;

    clip_t expected_clips[$];
    int    queries_sent = 0;
    int    clips_checked = 0;
    int    node_settings = 1;
    int    mismatch_count = 0;
    int    quiet_cycles = 0;
    int    idle_pct = BUSY_PCT;
    int    stall_pct = BUSY_PCT;

    octree_box_octant_classifier uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_index   (cfg_wr_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_query_low_x  (s_query_low_x),
        .s_query_low_y  (s_query_low_y),
        .s_query_low_z  (s_query_low_z),
        .s_query_high_x (s_query_high_x),
        .s_query_high_y (s_query_high_y),
        .s_query_high_z (s_query_high_z),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_inside_node  (m_inside_node),
        .m_home_octant  (m_home_octant),
        .m_fits_child   (m_fits_child),
        .m_touched_mask (m_touched_mask),
        .m_clip_octant  (m_clip_octant),
        .m_clip_low_x   (m_clip_low_x),
        .m_clip_low_y   (m_clip_low_y),
        .m_clip_low_z   (m_clip_low_z),
        .m_clip_high_x  (m_clip_high_x),
        .m_clip_high_y  (m_clip_high_y),
        .m_clip_high_z  (m_clip_high_z),
        .m_final_result (m_final_result)
    );

    always #5 aclk = ~aclk;

    // work out every clipped result of one query box against the current node box
    function automatic void classify_query(input obc_pkg::vec3_t qlo,
                                           input obc_pkg::vec3_t qhi);
        longint     nl[3];
        longint     nh[3];
        longint     ctr[3];
        longint     ql[3];
        longint     qh[3];
        longint     corner;
        longint     lo_v;
        longint     hi_v;
        logic       in_node;
        logic       ok;
        logic       plus;
        logic [3:0] home;
        logic [7:0] mask;
        logic [2:0] side;
        int         remaining;
        clip_t      r;
        in_node = 1'b1;
        home = obc_pkg::HOME_NONE;
        mask = '0;
        for (int a = 0; a < obc_pkg::NUM_AXES; a++) begin
            nl[a] = $signed(node_lo[a]);
            nh[a] = $signed(node_hi[a]);
            ql[a] = $signed(qlo[a]);
            qh[a] = $signed(qhi[a]);
            // floor of the mean, exact in 64 bits
            ctr[a] = (nl[a] + nh[a]) >>> 1;
            if (ql[a] < nl[a] || qh[a] > nh[a]) begin
                in_node = 1'b0;
            end
        end
        // first octant that wholly holds the box
        for (int k = 0; k < obc_pkg::NUM_OCTANTS; k++) begin
            if (home == obc_pkg::HOME_NONE) begin
                ok = 1'b1;
                for (int a = 0; a < obc_pkg::NUM_AXES; a++) begin
                    if (SIDES_OF_OCTANT[k][a]) begin
                        if (!(ql[a] >= ctr[a])) ok = 1'b0;
                    end else begin
                        if (!(qh[a] < ctr[a])) ok = 1'b0;
                    end
                end
                if (ok) begin
                    home = 4'(k);
                end
            end
        end
        // octants hit by the eight corners
        for (int k = 0; k < obc_pkg::NUM_OCTANTS; k++) begin
            for (int a = 0; a < obc_pkg::NUM_AXES; a++) begin
                corner = k[a] ? qh[a] : ql[a];
                side[a] = (corner >= ctr[a]);
            end
            mask[OCTANT_OF_SIDE[side]] = 1'b1;
        end
        remaining = $countones(mask);
        for (int k = 0; k < obc_pkg::NUM_OCTANTS; k++) begin
            if (mask[k]) begin
                r.in_node = in_node;
                r.home = home;
                r.fits = in_node && (home != obc_pkg::HOME_NONE);
                r.mask = mask;
                r.octant = 3'(k);
                for (int a = 0; a < obc_pkg::NUM_AXES; a++) begin
                    plus = SIDES_OF_OCTANT[k][a];
                    lo_v = plus ? ctr[a] : nl[a];
                    hi_v = plus ? nh[a] : ctr[a];
                    if (ql[a] > lo_v) lo_v = ql[a];
                    if (qh[a] < hi_v) hi_v = qh[a];
                    r.lo[a] = lo_v[obc_pkg::COORD_BITS-1:0];
                    r.hi[a] = hi_v[obc_pkg::COORD_BITS-1:0];
                end
                remaining--;
                r.last = (remaining == 0);
                expected_clips.push_back(r);
            end
        end
    endfunction

    function automatic obc_pkg::vec3_t splat(input obc_pkg::coord_t v);
        return {v, v, v};
    endfunction

    // random coordinate on one axis: mostly inside the node span, often on an edge or
    // next to the centre, sometimes anywhere
    function automatic obc_pkg::coord_t near_node(input int a);
        longint lo_l;
        longint hi_l;
        longint ctr;
        longint span;
        longint t;
        longint v;
        int     pick;
        lo_l = $signed(node_lo[a]);
        hi_l = $signed(node_hi[a]);
        ctr = (lo_l + hi_l) >>> 1;
        if (lo_l > hi_l) begin
            t = lo_l;
            lo_l = hi_l;
            hi_l = t;
        end
        span = hi_l - lo_l + 1;
        pick = $urandom_range(99);
        if (pick < 55) begin
            v = $urandom % span;
            v = lo_l + v;
        end else if (pick < 75) begin
            case ($urandom_range(4))
                0: v = lo_l;
                1: v = hi_l;
                2: v = ctr;
                3: v = ctr - 1;
                default: v = ctr + 1;
            endcase
        end else begin
            v = $urandom;
        end
        return v[obc_pkg::COORD_BITS-1:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < MAX_REPORTS) begin
            $display("%0t: mismatch on %s after %0d results: got %h want %h",
                     $realtime, what, clips_checked, got, want);
        end
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    // result side: compare each accepted result with the oldest expectation,
    // then pick the next cycle's ready at random
    always @(posedge aclk) begin : check_results
        clip_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_clips.size() == 0) begin
                report_mismatch("result with nothing expected", m_clip_octant, 0);
            end else begin
                want = expected_clips.pop_front();
                check_field("inside_node", m_inside_node, want.in_node);
                check_field("home_octant", m_home_octant, want.home);
                check_field("fits_child", m_fits_child, want.fits);
                check_field("touched_mask", m_touched_mask, want.mask);
                check_field("clip_octant", m_clip_octant, want.octant);
                check_field("clip_low_x", m_clip_low_x, want.lo[0]);
                check_field("clip_low_y", m_clip_low_y, want.lo[1]);
                check_field("clip_low_z", m_clip_low_z, want.lo[2]);
                check_field("clip_high_x", m_clip_high_x, want.hi[0]);
                check_field("clip_high_y", m_clip_high_y, want.hi[1]);
                check_field("clip_high_z", m_clip_high_z, want.hi[2]);
                check_field("final_result", m_final_result, want.last);
                clips_checked++;
            end
        end
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // watchdog: too long without any item moving on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, %0d results still expected", $realtime,
                     expected_clips.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // offer one query box, hold it until accepted, then predict its results
    task automatic send_query(input obc_pkg::vec3_t lo, input obc_pkg::vec3_t hi);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_query_low_x <= lo[0];
        s_query_low_y <= lo[1];
        s_query_low_z <= lo[2];
        s_query_high_x <= hi[0];
        s_query_high_y <= hi[1];
        s_query_high_z <= hi[2];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        classify_query(lo, hi);
        queries_sent++;
    endtask

    // stop offering and let every expected result come out
    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_clips.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // one register write; the enable is left high so writes can follow back to back
    task automatic write_reg(input logic [2:0] index, input obc_pkg::coord_t value);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= index;
        cfg_wr_data <= value;
        @(posedge aclk);
        case (index)
            obc_pkg::REG_NODE_LOW_X:  node_lo[0] = value;
            obc_pkg::REG_NODE_LOW_Y:  node_lo[1] = value;
            obc_pkg::REG_NODE_LOW_Z:  node_lo[2] = value;
            obc_pkg::REG_NODE_HIGH_X: node_hi[0] = value;
            obc_pkg::REG_NODE_HIGH_Y: node_hi[1] = value;
            obc_pkg::REG_NODE_HIGH_Z: node_hi[2] = value;
            default: ;
        endcase
    endtask

    task automatic set_node(input obc_pkg::vec3_t lo, input obc_pkg::vec3_t hi);
        write_reg(obc_pkg::REG_NODE_LOW_X, lo[0]);
        write_reg(obc_pkg::REG_NODE_LOW_Y, lo[1]);
        write_reg(obc_pkg::REG_NODE_LOW_Z, lo[2]);
        write_reg(obc_pkg::REG_NODE_HIGH_X, hi[0]);
        write_reg(obc_pkg::REG_NODE_HIGH_Y, hi[1]);
        write_reg(obc_pkg::REG_NODE_HIGH_Z, hi[2]);
        cfg_wr_en <= 1'b0;
        node_settings++;
    endtask

    task automatic set_random_node(input node_style_t style);
        obc_pkg::vec3_t  lo;
        obc_pkg::vec3_t  hi;
        obc_pkg::coord_t t;
        longint          s;
        for (int a = 0; a < obc_pkg::NUM_AXES; a++) begin
            lo[a] = $urandom;
            hi[a] = $urandom;
            if ($signed(lo[a]) > $signed(hi[a])) begin
                t = lo[a];
                lo[a] = hi[a];
                hi[a] = t;
            end
            if (style == NODE_SMALL) begin
                // narrow node, at most 1 << 20 wide (16.0 in Q16.16)
                s = $signed(lo[a]);
                s = s + int'($urandom_range(0, 1 << 20));
                if (s > COORD_TOP) s = COORD_TOP;
                hi[a] = s[obc_pkg::COORD_BITS-1:0];
            end else if (style == NODE_MIXED && $urandom_range(3) == 0) begin
                // inverted node on this axis
                t = lo[a];
                lo[a] = hi[a];
                hi[a] = t;
            end
        end
        set_node(lo, hi);
    endtask

    // mostly well-formed boxes, some at most Q_ONE wide on each axis, some inverted
    task automatic send_random_query();
        obc_pkg::vec3_t  lo;
        obc_pkg::vec3_t  hi;
        obc_pkg::coord_t t;
        longint          s;
        int              kind;
        kind = $urandom_range(99);
        for (int a = 0; a < obc_pkg::NUM_AXES; a++) begin
            lo[a] = near_node(a);
            hi[a] = near_node(a);
            if (kind < 90 && $signed(lo[a]) > $signed(hi[a])) begin
                t = lo[a];
                lo[a] = hi[a];
                hi[a] = t;
            end
            if (kind < 35) begin
                s = $signed(lo[a]);
                s = s + int'($urandom_range(0, Q_ONE));
                if (s > COORD_TOP) s = COORD_TOP;
                hi[a] = s[obc_pkg::COORD_BITS-1:0];
            end
        end
        send_query(lo, hi);
    endtask

    // node box still at its reset value: zero everywhere, centre zero
    task automatic test_reset_node();
        drain_results();
        send_query(splat(-1), splat(1));
        send_query(splat(0), splat(0));
        send_query(splat(Q_ONE), splat(5 * Q_ONE));
        send_query(splat(2), splat(-2));
    endtask

    // symmetric node around the origin, one box per octant plus edge cases
    task automatic test_octants();
        obc_pkg::vec3_t lo;
        obc_pkg::vec3_t hi;
        drain_results();
        set_node(splat(-8 * Q_ONE), splat(8 * Q_ONE));
        for (int k = 0; k < obc_pkg::NUM_OCTANTS; k++) begin
            for (int a = 0; a < obc_pkg::NUM_AXES; a++) begin
                lo[a] = SIDES_OF_OCTANT[k][a] ? Q_ONE : -2 * Q_ONE;
                hi[a] = SIDES_OF_OCTANT[k][a] ? 2 * Q_ONE : -Q_ONE;
            end
            send_query(lo, hi);
        end
        // whole node, box reaching past the low side of the node
        send_query(splat(-8 * Q_ONE), splat(8 * Q_ONE));
        send_query(splat(-9 * Q_ONE), splat(Q_ONE));
        // low exactly on the centre counts as the + side, high just below as the - side
        send_query(splat(0), splat(3 * Q_ONE));
        send_query(splat(-3 * Q_ONE), splat(-1));
        // straddling the centre on x only
        send_query({obc_pkg::coord_t'(Q_ONE), obc_pkg::coord_t'(Q_ONE),
                    obc_pkg::coord_t'(-Q_ONE)},
                   {obc_pkg::coord_t'(2 * Q_ONE), obc_pkg::coord_t'(2 * Q_ONE),
                    obc_pkg::coord_t'(Q_ONE)});
    endtask

    // widest and inverted node boxes, odd corners and extreme query values
    task automatic test_extremes();
        drain_results();
        // writes past the last register must leave the node box alone
        write_reg(REG_SPARE_A, COORD_MAX);
        write_reg(REG_SPARE_B, COORD_MIN);
        cfg_wr_en <= 1'b0;
        send_query(splat(-Q_ONE), splat(Q_ONE));
        drain_results();
        set_node(splat(COORD_MIN), splat(COORD_MAX));
        send_query(splat(COORD_MIN), splat(COORD_MAX));
        send_query(splat(COORD_MAX), splat(COORD_MIN));
        send_query(splat(COORD_MIN), splat(COORD_MIN));
        send_query(splat(COORD_MAX), splat(COORD_MAX));
        drain_results();
        // odd low and odd high: the sum is even, so the centre is exactly 1
        set_node(splat(-3), splat(5));
        send_query(splat(1), splat(1));
        send_query(splat(0), splat(2));
        drain_results();
        // inverted node box
        set_node(splat(4 * Q_ONE), splat(-4 * Q_ONE));
        send_query(splat(-Q_ONE), splat(Q_ONE));
        send_query(splat(COORD_MIN), splat(COORD_MAX));
    endtask

    // random node boxes of several shapes, random queries against each
    task automatic test_random_boxes();
        for (int ph = 0; ph < 4; ph++) begin
            drain_results();
            set_random_node(node_style_t'(ph % 3));
            repeat (44) send_random_query();
        end
    endtask

    // back to back queries with ready always high, so the queue fills up
    task automatic test_burst();
        drain_results();
        set_random_node(NODE_WIDE);
        idle_pct = 0;
        stall_pct = 0;
        repeat (30) send_random_query();
        drain_results();
        idle_pct = BUSY_PCT;
        stall_pct = BUSY_PCT;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_node();
        test_octants();
        test_extremes();
        test_random_boxes();
        test_burst();
        drain_results();
        $display("%0d query boxes against %0d node box settings, %0d clipped results compared",
                 queries_sent, node_settings, clips_checked);
        $display("%0d field mismatches", mismatch_count);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
